// ===== src/ucfd_pkg.sv =====
`default_nettype none
package ucfd_pkg;

  localparam int FRAME_DEPTH = 16;
  localparam int IDX_W = $clog2(FRAME_DEPTH);
  localparam int CNT_W = $clog2(FRAME_DEPTH + 1);
  localparam int DIV_W = 16;
  localparam int DCNT_W = $clog2(DIV_W + 1);

  localparam logic [7:0] SYNC_BYTE = 8'hFE;
  localparam logic [7:0] END_BYTE  = 8'h16;
  localparam logic [7:0] LEN_BYTE  = 8'h05;
  localparam logic [7:0] ARG_READ  = 8'hAA;

  localparam logic [7:0] CODE_KP    = 8'hA0;
  localparam logic [7:0] CODE_KI    = 8'hA1;
  localparam logic [7:0] CODE_KD    = 8'hA2;
  localparam logic [7:0] CODE_CUR   = 8'hA3;
  localparam logic [7:0] CODE_STEP  = 8'hA4;
  localparam logic [7:0] CODE_EN    = 8'hA5;
  localparam logic [7:0] CODE_DIR   = 8'hA6;
  localparam logic [7:0] CODE_RGAIN = 8'hB0;
  localparam logic [7:0] CODE_RCUR  = 8'hB1;
  localparam logic [7:0] CODE_RSTEP = 8'hB2;
  localparam logic [7:0] CODE_REN   = 8'hB3;
  localparam logic [7:0] CODE_RDIR  = 8'hB4;
  localparam logic [7:0] CODE_MIN   = 8'hA0;
  localparam logic [7:0] CODE_MAX   = 8'hBF;

  localparam logic [15:0] EN_ACT_LOW  = 16'h00AA;
  localparam logic [15:0] EN_ACT_HIGH = 16'h0055;
  localparam logic [15:0] DIR_FWD     = 16'h0011;
  localparam logic [15:0] DIR_REV     = 16'h0022;

  localparam logic [15:0] CUR_SCALE  = 16'd100;
  localparam logic [15:0] STEP_FULL  = 16'd64;
  localparam logic [15:0] GEAR_FULL  = 16'd16384;

  // divide by 100 as multiply by ceil(2^23 / 100) and shift, exact for 16-bit values
  localparam logic [16:0] CUR_RECIP = 17'd83887;
  localparam int          CUR_SHIFT = 23;

  localparam logic [2:0] STS_WRITE_OK  = 3'd0;
  localparam logic [2:0] STS_READ      = 3'd1;
  localparam logic [2:0] STS_FRAME_ERR = 3'd2;
  localparam logic [2:0] STS_CHK_ERR   = 3'd3;
  localparam logic [2:0] STS_LEN_ERR   = 3'd4;
  localparam logic [2:0] STS_RANGE_ERR = 3'd5;
  localparam logic [2:0] STS_UNDEF     = 3'd6;
  localparam logic [2:0] STS_ARG_ERR   = 3'd7;

  localparam logic [2:0] ITEM_KP    = 3'd0;
  localparam logic [2:0] ITEM_KI    = 3'd1;
  localparam logic [2:0] ITEM_KD    = 3'd2;
  localparam logic [2:0] ITEM_CUR   = 3'd3;
  localparam logic [2:0] ITEM_STEP  = 3'd4;
  localparam logic [2:0] ITEM_GEAR  = 3'd5;
  localparam logic [2:0] ITEM_EN    = 3'd6;
  localparam logic [2:0] ITEM_DIR   = 3'd7;

  typedef enum logic [2:0] {
    ST_IDLE, ST_WALK, ST_DIVA_GO, ST_DIVA_WAIT, ST_DIVB_GO, ST_DIVB_WAIT, ST_APPLY, ST_SEND
  } state_t;

  typedef struct packed {
    logic wr;
    logic walk_init;
    logic walk;
    logic div_start;
    logic div_b;
    logic apply;
    logic next;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic bad;
    logic walk_done;
    logic need_diva;
    logic need_divb;
    logic div_done;
    logic last;
  } dp_stat_t;

endpackage
`default_nettype wire

// ===== src/uart_command_frame_decoder.sv =====
// a data byte is taken and causes no result
// an idle item walks the frame buffer (skipped for a frame under three bytes or overflowed), then
// two 16-step divisions run for a valid step command or step read; current is scaled by a multiply
// results leave one per cycle from the decode registers while out_tready is high;
// the next item is taken after the last
// synchronous active-low reset clears counters and settings (step divisor to one); buffer not cleared
`default_nettype none
module uart_command_frame_decoder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // rx_byte
  input  wire logic        in_tuser,   // cmd
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // item[2:0] value[18:3] store_request[19] loop_reinit[20] enable_mode_out[21]
  // direction_out[22] current_code_out[32:23] step_divisor_out[39:33]
  output logic [39:0]      out_tdata,
  output logic [2:0]       out_tuser,  // status
  output logic             out_tlast
);

  ucfd_pkg::ctrl_cmd_t cmd;
  ucfd_pkg::dp_stat_t  stat;
  logic [2:0]  item;
  logic [15:0] value;
  logic        store_request, loop_reinit, en, dir;
  logic [9:0]  cur;
  logic [6:0]  sd;

  ucfd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tuser   (in_tuser),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid)
  );

  ucfd_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .rx_byte          (in_tdata),
    .stat             (stat),
    .status           (out_tuser),
    .item             (item),
    .value            (value),
    .last             (out_tlast),
    .store_request    (store_request),
    .loop_reinit      (loop_reinit),
    .enable_mode_out  (en),
    .direction_out    (dir),
    .current_code_out (cur),
    .step_divisor_out (sd)
  );

  assign out_tdata = {sd, cur, dir, en, loop_reinit, store_request, value, item};

`ifndef SYNTHESIS
  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid)) else $error("input and output active together");
  a_back_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> in_tready) else $error("no return to idle");
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ucfd_pkg::STS_FRAME_ERR || out_tuser == ucfd_pkg::STS_CHK_ERR ||
    out_tuser == ucfd_pkg::STS_LEN_ERR) |-> out_tlast) else $error("error item not last");
`endif

endmodule
`default_nettype wire

// ===== src/ucfd_div.sv =====
`default_nettype none
module ucfd_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [ucfd_pkg::DIV_W-1:0]  dividend,
  input  wire logic [ucfd_pkg::DIV_W-1:0]  divisor,
  output logic                             done,
  output logic [ucfd_pkg::DIV_W-1:0]       quotient
);

  logic [ucfd_pkg::DIV_W-1:0]  quo_r, quo_nxt;
  logic [ucfd_pkg::DIV_W-1:0]  rem_r, rem_nxt;
  logic [ucfd_pkg::DIV_W-1:0]  dsr_r;
  logic [ucfd_pkg::DCNT_W-1:0] cnt_r;
  logic                        busy_r, done_r;
  logic [ucfd_pkg::DIV_W:0]    rem_sh;

  // one restoring step a cycle
  always_comb begin
    rem_sh = {rem_r, quo_r[ucfd_pkg::DIV_W-1]};
    if (rem_sh >= {1'b0, dsr_r}) begin
      rem_nxt = ucfd_pkg::DIV_W'(rem_sh - {1'b0, dsr_r});
      quo_nxt = {quo_r[ucfd_pkg::DIV_W-2:0], 1'b1};
    end else begin
      rem_nxt = rem_sh[ucfd_pkg::DIV_W-1:0];
      quo_nxt = {quo_r[ucfd_pkg::DIV_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= ucfd_pkg::DCNT_W'(ucfd_pkg::DIV_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == ucfd_pkg::DCNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      dsr_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  // zero divisor gives zero
  assign quotient = (dsr_r == '0) ? '0 : quo_r;

endmodule
`default_nettype wire

// ===== src/ucfd_dp.sv =====
`default_nettype none
module ucfd_dp (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire ucfd_pkg::ctrl_cmd_t  cmd,
  input  wire logic [7:0]           rx_byte,
  output ucfd_pkg::dp_stat_t        stat,
  output logic [2:0]                status,
  output logic [2:0]                item,
  output logic [15:0]               value,
  output logic                      last,
  output logic                      store_request,
  output logic                      loop_reinit,
  output logic                      enable_mode_out,
  output logic                      direction_out,
  output logic [9:0]                current_code_out,
  output logic [6:0]                step_divisor_out
);

  localparam int CW = ucfd_pkg::CNT_W;

  logic [7:0]    mem [ucfd_pkg::FRAME_DEPTH];
  logic [CW-1:0] byte_cnt_r;
  logic          ovf_r;
  logic [CW-1:0] rd_k_r, pk_r;
  logic          pv_r;
  logic [7:0]    rdata_r;
  logic [7:0]    sum_r, chk_r, len_r, code_r, hi_r, lo_r;
  logic          ok0_r, ok1_r, okend_r;
  logic [1:0]    idx_r;
  logic [15:0]   qa_r, qb_r;
  logic [15:0]   gp_r, gi_r, gd_r;
  logic [9:0]    cur_r;
  logic [6:0]    sd_r;
  logic          en_r, dir_r;

  logic          div_done;
  logic [15:0]   div_q, div_dvd, div_dsr;
  logic [15:0]   arg;
  logic [CW:0]   k_ext, n_ext;
  logic          frame_ok, dec_ok, arg_ok, rd_step;
  logic [1:0]    cnt;
  logic [15:0]   cur_ma;
  logic [32:0]   cur_prod;
  logic [9:0]    cur_q;

  assign arg    = {hi_r, lo_r};
  assign arg_ok = (hi_r == ucfd_pkg::ARG_READ) && (lo_r == ucfd_pkg::ARG_READ);
  assign k_ext  = {1'b0, pk_r};
  assign n_ext  = {1'b0, byte_cnt_r};
  assign frame_ok = !stat.bad && ok0_r && ok1_r && okend_r;
  assign dec_ok = frame_ok && (sum_r == chk_r) && (len_r == ucfd_pkg::LEN_BYTE);
  assign rd_step = (code_r == ucfd_pkg::CODE_RSTEP) && arg_ok;
  assign cur_ma = 16'(cur_r * 7'd100);
  assign cur_prod = {17'd0, arg} * {16'd0, ucfd_pkg::CUR_RECIP};
  assign cur_q    = cur_prod[ucfd_pkg::CUR_SHIFT +: 10];

  always_comb begin
    stat.bad       = ovf_r || (byte_cnt_r < CW'(3));
    stat.walk_done = cmd.walk && (rd_k_r == byte_cnt_r) && !pv_r;
    stat.need_diva = dec_ok && (code_r == ucfd_pkg::CODE_STEP || rd_step);
    stat.need_divb = dec_ok && (code_r == ucfd_pkg::CODE_STEP || rd_step);
    stat.div_done  = div_done;
    stat.last      = (idx_r == cnt - 2'd1);
  end

  always_comb begin
    div_dvd = ucfd_pkg::STEP_FULL;
    div_dsr = {9'd0, sd_r};
    if (!cmd.div_b) begin
      if (code_r == ucfd_pkg::CODE_STEP) begin
        div_dsr = arg;
      end
    end else begin
      if (code_r == ucfd_pkg::CODE_STEP) div_dsr = {9'd0, qa_r[6:0]};
      else div_dvd = ucfd_pkg::GEAR_FULL;
    end
  end

  ucfd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (cmd.wr && byte_cnt_r < CW'(ucfd_pkg::FRAME_DEPTH))
      mem[byte_cnt_r[ucfd_pkg::IDX_W-1:0]] <= rx_byte;
    rdata_r <= mem[rd_k_r[ucfd_pkg::IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_cnt_r <= '0;
      ovf_r      <= 1'b0;
      rd_k_r     <= '0;
      pv_r       <= 1'b0;
      idx_r      <= '0;
      gp_r       <= '0;
      gi_r       <= '0;
      gd_r       <= '0;
      cur_r      <= '0;
      sd_r       <= 7'd1;
      en_r       <= 1'b0;
      dir_r      <= 1'b0;
    end else begin
      if (cmd.wr) begin
        if (byte_cnt_r < CW'(ucfd_pkg::FRAME_DEPTH)) byte_cnt_r <= byte_cnt_r + 1'b1;
        else ovf_r <= 1'b1;
      end
      if (cmd.finish) begin
        byte_cnt_r <= '0;
        ovf_r      <= 1'b0;
      end
      if (cmd.walk_init) begin
        rd_k_r <= '0;
        pv_r   <= 1'b0;
        idx_r  <= '0;
      end else if (cmd.walk) begin
        if (rd_k_r < byte_cnt_r) begin
          rd_k_r <= rd_k_r + 1'b1;
          pv_r   <= 1'b1;
        end else begin
          pv_r <= 1'b0;
        end
      end
      if (cmd.next) idx_r <= idx_r + 1'b1;
      if (cmd.apply && dec_ok) begin
        case (code_r)
          ucfd_pkg::CODE_KP:   gp_r  <= arg;
          ucfd_pkg::CODE_KI:   gi_r  <= arg;
          ucfd_pkg::CODE_KD:   gd_r  <= arg;
          ucfd_pkg::CODE_CUR:  cur_r <= cur_q;
          ucfd_pkg::CODE_STEP: sd_r  <= qa_r[6:0];
          ucfd_pkg::CODE_EN: begin
            if (arg == ucfd_pkg::EN_ACT_LOW) en_r <= 1'b0;
            else if (arg == ucfd_pkg::EN_ACT_HIGH) en_r <= 1'b1;
          end
          ucfd_pkg::CODE_DIR: begin
            if (arg == ucfd_pkg::DIR_FWD) dir_r <= 1'b1;
            else if (arg == ucfd_pkg::DIR_REV) dir_r <= 1'b0;
          end
          default: ;
        endcase
      end
    end
  end

  // frame checks as the buffer is walked, one byte a cycle
  always_ff @(posedge clk) begin
    pk_r <= rd_k_r;
    if (cmd.walk_init) begin
      sum_r   <= '0;
      ok0_r   <= 1'b0;
      ok1_r   <= 1'b0;
      okend_r <= 1'b0;
    end else if (cmd.walk && pv_r) begin
      if (k_ext == '0) ok0_r <= (rdata_r == ucfd_pkg::SYNC_BYTE);
      if (k_ext == (CW+1)'(1)) ok1_r <= (rdata_r == ucfd_pkg::SYNC_BYTE);
      if (k_ext + 1'b1 == n_ext) okend_r <= (rdata_r == ucfd_pkg::END_BYTE);
      if (k_ext + (CW+1)'(2) == n_ext) chk_r <= rdata_r;
      if (k_ext >= (CW+1)'(2) && k_ext + (CW+1)'(3) <= n_ext) sum_r <= sum_r + rdata_r;
      if (k_ext == (CW+1)'(2)) len_r  <= rdata_r;
      if (k_ext == (CW+1)'(3)) code_r <= rdata_r;
      if (k_ext == (CW+1)'(4)) hi_r   <= rdata_r;
      if (k_ext == (CW+1)'(5)) lo_r   <= rdata_r;
    end
    if (div_done) begin
      if (cmd.div_b) qb_r <= div_q;
      else qa_r <= div_q;
    end
  end

  always_comb begin
    status        = ucfd_pkg::STS_FRAME_ERR;
    item          = ucfd_pkg::ITEM_KP;
    value         = '0;
    store_request = 1'b0;
    loop_reinit   = 1'b0;
    cnt           = 2'd1;
    if (!frame_ok) begin
      status = ucfd_pkg::STS_FRAME_ERR;
    end else if (sum_r != chk_r) begin
      status = ucfd_pkg::STS_CHK_ERR;
    end else if (len_r != ucfd_pkg::LEN_BYTE) begin
      status = ucfd_pkg::STS_LEN_ERR;
    end else if (code_r < ucfd_pkg::CODE_MIN || code_r > ucfd_pkg::CODE_MAX) begin
      status        = ucfd_pkg::STS_RANGE_ERR;
      store_request = 1'b1;
    end else begin
      status        = ucfd_pkg::STS_WRITE_OK;
      store_request = 1'b1;
      case (code_r) inside
        ucfd_pkg::CODE_KP: value = gp_r;
        ucfd_pkg::CODE_KI: begin item = ucfd_pkg::ITEM_KI; value = gi_r; end
        ucfd_pkg::CODE_KD: begin item = ucfd_pkg::ITEM_KD; value = gd_r; end
        ucfd_pkg::CODE_CUR: begin item = ucfd_pkg::ITEM_CUR; value = cur_ma; end
        ucfd_pkg::CODE_STEP: begin
          item        = ucfd_pkg::ITEM_STEP;
          value       = qb_r;
          loop_reinit = 1'b1;
        end
        ucfd_pkg::CODE_EN: begin
          item        = ucfd_pkg::ITEM_EN;
          value       = {15'd0, en_r};
          loop_reinit = 1'b1;
        end
        ucfd_pkg::CODE_DIR: begin item = ucfd_pkg::ITEM_DIR; value = {15'd0, dir_r}; end
        [ucfd_pkg::CODE_RGAIN:ucfd_pkg::CODE_RDIR]: begin
          if (!arg_ok) begin
            status = ucfd_pkg::STS_ARG_ERR;
          end else begin
            status        = ucfd_pkg::STS_READ;
            store_request = 1'b0;
            case (code_r)
              ucfd_pkg::CODE_RGAIN: begin
                cnt = 2'd3;
                if (idx_r == 2'd0) value = gp_r;
                else if (idx_r == 2'd1) begin item = ucfd_pkg::ITEM_KI; value = gi_r; end
                else begin item = ucfd_pkg::ITEM_KD; value = gd_r; end
              end
              ucfd_pkg::CODE_RCUR: begin item = ucfd_pkg::ITEM_CUR; value = cur_ma; end
              ucfd_pkg::CODE_RSTEP: begin
                cnt = 2'd2;
                if (idx_r == 2'd0) begin item = ucfd_pkg::ITEM_STEP; value = qa_r; end
                else begin item = ucfd_pkg::ITEM_GEAR; value = qb_r; end
              end
              ucfd_pkg::CODE_REN: begin item = ucfd_pkg::ITEM_EN; value = {15'd0, en_r}; end
              default: begin item = ucfd_pkg::ITEM_DIR; value = {15'd0, dir_r}; end
            endcase
          end
        end
        default: status = ucfd_pkg::STS_UNDEF;
      endcase
    end
  end

  assign last             = stat.last;
  assign enable_mode_out  = en_r;
  assign direction_out    = dir_r;
  assign current_code_out = cur_r;
  assign step_divisor_out = sd_r;

endmodule
`default_nettype wire

// ===== src/ucfd_ctrl.sv =====
`default_nettype none
module ucfd_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  input  wire logic                in_tuser,
  input  wire logic                out_tready,
  input  wire ucfd_pkg::dp_stat_t  stat,
  output ucfd_pkg::ctrl_cmd_t      cmd,
  output logic                     in_tready,
  output logic                     out_tvalid
);

  ucfd_pkg::state_t state_r, state_nxt;
  logic in_acc, out_acc;

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ucfd_pkg::ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ucfd_pkg::ST_IDLE:
        if (in_acc && in_tuser) state_nxt = stat.bad ? ucfd_pkg::ST_SEND : ucfd_pkg::ST_WALK;
      ucfd_pkg::ST_WALK:
        if (stat.walk_done)
          state_nxt = stat.need_diva ? ucfd_pkg::ST_DIVA_GO : ucfd_pkg::ST_APPLY;
      ucfd_pkg::ST_DIVA_GO: state_nxt = ucfd_pkg::ST_DIVA_WAIT;
      ucfd_pkg::ST_DIVA_WAIT:
        if (stat.div_done)
          state_nxt = stat.need_divb ? ucfd_pkg::ST_DIVB_GO : ucfd_pkg::ST_APPLY;
      ucfd_pkg::ST_DIVB_GO: state_nxt = ucfd_pkg::ST_DIVB_WAIT;
      ucfd_pkg::ST_DIVB_WAIT:
        if (stat.div_done) state_nxt = ucfd_pkg::ST_APPLY;
      ucfd_pkg::ST_APPLY: state_nxt = ucfd_pkg::ST_SEND;
      ucfd_pkg::ST_SEND:
        if (out_acc && stat.last) state_nxt = ucfd_pkg::ST_IDLE;
      default: state_nxt = ucfd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    unique case (state_r)
      ucfd_pkg::ST_IDLE: begin
        in_tready     = 1'b1;
        cmd.wr        = in_acc && !in_tuser;
        cmd.walk_init = in_acc && in_tuser;
      end
      ucfd_pkg::ST_WALK: cmd.walk = 1'b1;
      ucfd_pkg::ST_DIVA_GO: cmd.div_start = 1'b1;
      ucfd_pkg::ST_DIVA_WAIT: ;
      ucfd_pkg::ST_DIVB_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_b     = 1'b1;
      end
      ucfd_pkg::ST_DIVB_WAIT: cmd.div_b = 1'b1;
      ucfd_pkg::ST_APPLY: cmd.apply = 1'b1;
      ucfd_pkg::ST_SEND: begin
        out_tvalid = 1'b1;
        cmd.next   = out_acc && !stat.last;
        cmd.finish = out_acc && stat.last;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire
